// ----- hdl/gnhf_pkg.sv -----
// Package for the greedy non-overlapping hit filter.
// Shared types and constants; no dependencies.
package gnhf_pkg;

    localparam int MAX_HITS_DEF   = 64;
    localparam int WINDOW_LEN_DEF = 4096;
    localparam int POS_W   = 24;
    localparam int SCORE_W = 32;
    localparam int TAG_W   = 16;
    localparam int HIT_W   = 2 * POS_W + SCORE_W + TAG_W;

    localparam logic CFG_WINDOW_FIRST = 1'b0;
    localparam logic CFG_WINDOW_LAST  = 1'b1;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_CLEAR,
        ST_SORT_FETCH,
        ST_SORT_CUR,
        ST_SORT_ORD,
        ST_SORT_CMP,
        ST_SORT_PUT,
        ST_FLT_IDX,
        ST_FLT_ADDR,
        ST_FLT_HIT,
        ST_FLT_CHK,
        ST_FLT_SCAN,
        ST_FLT_MARK,
        ST_OUT_IDX,
        ST_OUT_ADDR,
        ST_OUT_LD,
        ST_OUT_HOLD
    } state_t;

endpackage

// ----- hdl/gnhf_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module gnhf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hdl/greedy_nonoverlap_hit_filter.sv -----
// Greedy non-overlapping hit filter, top level.
// Loading takes one hit per cycle. On s_tlast: a map clear of WINDOW_LEN
// positions; an insertion sort, up to MAX_HITS*(MAX_HITS-1)/2 shift steps in all;
// then per hit a scan of its positions until a covered one is found, and a mark
// of every position of a kept hit; then each result goes out and waits for
// m_tready, dropped hits skipped. The block takes no hit until the last result
// leaves. Async active-low reset.
module greedy_nonoverlap_hit_filter
    import gnhf_pkg::*;
#(
    parameter int MAX_HITS   = MAX_HITS_DEF,
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // hit_start[23:0], hit_stop[47:24], hit_score[79:48], hit_tag[95:80]
    input  logic [95:0]  s_tdata,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // kept_start[23:0], kept_stop[47:24], kept_score[79:48], kept_tag[95:80]
    output logic [95:0]  m_tdata,
    output logic         m_tlast,
    // overflowed
    output logic         m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [23:0]  cfg_data
);
    localparam int AW = $clog2(MAX_HITS);
    localparam int CW = $clog2(MAX_HITS + 1);
    localparam int MW = $clog2(WINDOW_LEN);

    state_t state_reg, state_next;
    logic [POS_W-1:0] wfirst_reg, wlast_reg;
    logic [CW-1:0] count_reg, count_next;
    logic ovf_reg, ovf_next;
    // sort: i = hit being inserted, j = slot, order held in order RAM
    logic [CW-1:0] i_reg, i_next, j_reg, j_next;
    logic [MW-1:0] clr_reg, clr_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [CW-1:0] kept_reg, kept_next, total_reg, total_next;
    logic [HIT_W-1:0] cur_reg, cur_next;
    logic [HIT_W-1:0] out_reg, out_next;
    logic out_last_reg, out_last_next;

    // hit store
    logic hit_we;
    logic [AW-1:0] hit_waddr, hit_raddr;
    logic [HIT_W-1:0] hit_rdata;
    // order store (index list), kept flag in MSB
    logic ord_we;
    logic [AW-1:0] ord_waddr, ord_raddr;
    logic [AW:0] ord_wdata, ord_rdata;
    // coverage map
    logic map_we, map_wdata, map_rdata;
    logic [MW-1:0] map_waddr, map_raddr;

    gnhf_ram #(.WIDTH(HIT_W), .DEPTH(MAX_HITS)) u_hits (
        .clk(clk), .we(hit_we), .waddr(hit_waddr), .wdata(s_tdata[HIT_W-1:0]),
        .raddr(hit_raddr), .rdata(hit_rdata));
    gnhf_ram #(.WIDTH(AW + 1), .DEPTH(MAX_HITS)) u_order (
        .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
        .raddr(ord_raddr), .rdata(ord_rdata));
    gnhf_ram #(.WIDTH(1), .DEPTH(WINDOW_LEN)) u_map (
        .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
        .raddr(map_raddr), .rdata(map_rdata));

    // field views
    logic [POS_W-1:0] cs, ce, rs;
    logic signed [SCORE_W-1:0] csc, rsc;
    assign cs  = cur_reg[POS_W-1:0];
    assign ce  = cur_reg[2*POS_W-1:POS_W];
    assign csc = cur_reg[2*POS_W+SCORE_W-1:2*POS_W];
    assign rs  = hit_rdata[POS_W-1:0];
    assign rsc = hit_rdata[2*POS_W+SCORE_W-1:2*POS_W];

    // shared compare unit: current hit goes strictly before read hit
    logic cur_before;
    assign cur_before = (csc != rsc) ? (csc > rsc) : (cs > rs);

    // window check for current hit
    logic [POS_W-1:0] span;
    logic in_win;
    assign span = ce - wfirst_reg;
    assign in_win = !(cs < wfirst_reg || ce > wlast_reg || {8'd0, span} >= 32'(WINDOW_LEN));

    // index of the hit under work, as read from the order RAM
    logic [AW-1:0] moved_reg, moved_next;

    assign s_tready  = (state_reg == ST_LOAD);
    // Hold register writes off while a list is being filtered or emitted.
    assign cfg_ready = (state_reg == ST_LOAD);
    assign m_tvalid  = (state_reg == ST_OUT_HOLD);
    assign m_tdata   = out_reg;
    assign m_tlast   = out_last_reg;
    assign m_tuser   = ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_LOAD;
            wfirst_reg <= 24'd1;
            wlast_reg  <= 24'd4096;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            i_reg      <= '0;
            j_reg      <= '0;
            clr_reg    <= '0;
            kept_reg   <= '0;
            total_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            clr_reg   <= clr_next;
            kept_reg  <= kept_next;
            total_reg <= total_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_WINDOW_FIRST: wfirst_reg <= cfg_data;
                    CFG_WINDOW_LAST:  wlast_reg  <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        cur_reg      <= cur_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
        moved_reg    <= moved_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
                if (s_tvalid && s_tlast) state_next = ST_CLEAR;
            ST_CLEAR:
                if (clr_reg == MW'(WINDOW_LEN - 1)) state_next = ST_SORT_FETCH;
            ST_SORT_FETCH:
                state_next = (i_reg == count_reg) ? ST_FLT_IDX : ST_SORT_CUR;
            ST_SORT_CUR:
                state_next = (j_reg == '0) ? ST_SORT_PUT : ST_SORT_ORD;
            ST_SORT_ORD:
                state_next = ST_SORT_CMP;
            ST_SORT_CMP:
                if (cur_before && j_reg != CW'(1)) state_next = ST_SORT_ORD;
                else state_next = ST_SORT_PUT;
            ST_SORT_PUT:
                state_next = ST_SORT_FETCH;
            ST_FLT_IDX:
                state_next = (i_reg == count_reg) ?
                    ((total_reg == '0) ? ST_LOAD : ST_OUT_IDX) : ST_FLT_ADDR;
            ST_FLT_ADDR:
                state_next = ST_FLT_HIT;
            ST_FLT_HIT:
                state_next = ST_FLT_CHK;
            ST_FLT_CHK:
                if (cs > ce || !in_win) state_next = ST_FLT_IDX;
                else state_next = ST_FLT_SCAN;
            ST_FLT_SCAN:
                if (map_rdata) state_next = ST_FLT_IDX;
                else if (pos_reg == ce) state_next = ST_FLT_MARK;
            ST_FLT_MARK:
                if (pos_reg == ce) state_next = ST_FLT_IDX;
            ST_OUT_IDX:
                state_next = (i_reg == count_reg) ? ST_LOAD : ST_OUT_ADDR;
            ST_OUT_ADDR:
                state_next = ord_rdata[AW] ? ST_OUT_LD : ST_OUT_IDX;
            ST_OUT_LD:
                state_next = ST_OUT_HOLD;
            ST_OUT_HOLD:
                if (m_tready) state_next = (out_last_reg ? ST_LOAD : ST_OUT_IDX);
            default:
                state_next = ST_LOAD;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        clr_next      = clr_reg;
        pos_next      = pos_reg;
        kept_next     = kept_reg;
        total_next    = total_reg;
        cur_next      = cur_reg;
        out_next      = out_reg;
        out_last_next = out_last_reg;
        moved_next    = moved_reg;
        hit_we    = 1'b0;
        hit_waddr = count_reg[AW-1:0];
        hit_raddr = i_reg[AW-1:0];
        ord_we    = 1'b0;
        ord_waddr = j_reg[AW-1:0];
        ord_wdata = {1'b0, i_reg[AW-1:0]};
        ord_raddr = i_reg[AW-1:0];
        map_we    = 1'b0;
        map_waddr = clr_reg;
        map_wdata = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (s_tvalid)
                begin
                    if (count_reg < CW'(MAX_HITS))
                    begin
                        hit_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                clr_next   = '0;
                i_next     = '0;
                j_next     = '0;
                total_next = '0;
                kept_next  = '0;
            end
            ST_CLEAR:
            begin
                map_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
            end
            ST_SORT_FETCH:
            begin
                // read hit i; it is inserted starting from slot i
                j_next = i_reg;
                if (i_reg == count_reg)
                    i_next = '0;
            end
            ST_SORT_CUR:
            begin
                cur_next  = hit_rdata;
                ord_raddr = AW'(j_reg - 1'b1);
            end
            ST_SORT_ORD:
            begin
                hit_raddr  = ord_rdata[AW-1:0];
                moved_next = ord_rdata[AW-1:0];
            end
            ST_SORT_CMP:
            begin
                // shift the ranked-lower entry up one slot
                if (cur_before)
                begin
                    ord_we    = 1'b1;
                    ord_wdata = {1'b0, moved_reg};
                    j_next    = j_reg - 1'b1;
                    ord_raddr = AW'(j_reg - 2'd2);
                end
            end
            ST_SORT_PUT:
            begin
                ord_we = 1'b1;
                i_next = i_reg + 1'b1;
            end
            ST_FLT_IDX:
            begin
                if (i_reg == count_reg)
                begin
                    i_next    = '0;
                    kept_next = '0;
                    if (total_reg == '0)
                    begin
                        // nothing kept: drop the list, overflow included
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end
                end
            end
            ST_FLT_ADDR:
            begin
                hit_raddr  = ord_rdata[AW-1:0];
                moved_next = ord_rdata[AW-1:0];
            end
            ST_FLT_HIT:
            begin
                cur_next = hit_rdata;
            end
            ST_FLT_CHK:
            begin
                pos_next = cs;
                if (cs > ce)
                begin
                    // reversed hit covers nothing and is always kept
                    ord_we     = 1'b1;
                    ord_waddr  = i_reg[AW-1:0];
                    ord_wdata  = {1'b1, moved_reg};
                    total_next = total_reg + 1'b1;
                    i_next     = i_reg + 1'b1;
                end
                else if (!in_win)
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            ST_FLT_SCAN:
            begin
                if (map_rdata)
                    i_next = i_reg + 1'b1;
                else if (pos_reg == ce)
                    pos_next = cs;
                else
                    pos_next = pos_reg + 1'b1;
            end
            ST_FLT_MARK:
            begin
                map_we    = 1'b1;
                map_waddr = MW'(pos_reg - wfirst_reg);
                map_wdata = 1'b1;
                if (pos_reg == ce)
                begin
                    ord_we     = 1'b1;
                    ord_waddr  = i_reg[AW-1:0];
                    ord_wdata  = {1'b1, moved_reg};
                    total_next = total_reg + 1'b1;
                    i_next     = i_reg + 1'b1;
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
            ST_OUT_IDX:
            begin
                if (i_reg == count_reg)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                end
            end
            ST_OUT_ADDR:
            begin
                hit_raddr = ord_rdata[AW-1:0];
                i_next    = i_reg + 1'b1;
            end
            ST_OUT_LD:
            begin
                out_next      = hit_rdata;
                out_last_next = (kept_reg + 1'b1 == total_reg);
                kept_next     = kept_reg + 1'b1;
            end
            ST_OUT_HOLD:
            begin
                if (m_tready && out_last_reg)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                end
            end
            default: ;
        endcase
        // read the map one position ahead of the scan
        map_raddr = MW'(pos_next - wfirst_reg);
    end

    // no hit is taken while a result waits
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid));
    // a waiting result holds still
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                     && $stable(m_tuser)));
    // results only come from a list with kept hits
    a_total: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (total_reg != '0));
endmodule
